@@ sv/dmtt_pkg.sv @@
// ============================================================================
// dmtt_pkg: shared types and constants of the transposition table
// Field widths, command and bound codes, entry layout and the result record.
// ============================================================================
package dmtt_pkg;

  localparam int unsigned KEY_W    = 64;
  localparam int unsigned SCORE_W  = 18;
  localparam int unsigned DEPTH_W  = 8;
  localparam int unsigned SDEPTH_W = 7;
  localparam int unsigned AGE_W    = 7;
  localparam int unsigned PLY_W    = 7;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned MOVE_W   = 16;
  localparam int unsigned CMD_W    = 2;

  localparam int unsigned IN_TDATA_W  = 152;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_TUSER_W = 2;

  localparam logic [CMD_W-1:0] CMD_PROBE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STORE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd3;

  localparam logic [KIND_W-1:0] KIND_EXACT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UPPER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOWER = 2'd2;

  localparam logic signed [SCORE_W:0] MATE_EDGE   = 19'sd90000;
  localparam logic signed [SCORE_W:0] SCORE_LIMIT = 19'sd131071;

  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic signed [SCORE_W-1:0] score;
    logic [SDEPTH_W-1:0]       depth;
    logic [AGE_W-1:0]          age;
    logic [KIND_W-1:0]         kind;
    logic [MOVE_W-1:0]         move;
  } entry_t;

  typedef struct packed {
    logic [KEY_W-1:0]          position_key;
    logic signed [DEPTH_W-1:0] depth;
    logic signed [SCORE_W-1:0] alpha_bound;
    logic signed [SCORE_W-1:0] beta_bound;
    logic [PLY_W-1:0]          ply;
    logic signed [SCORE_W-1:0] score;
    logic [KIND_W-1:0]         bound_kind;
    logic [MOVE_W-1:0]         move;
  } req_t;

  typedef struct packed {
    logic                      key_matched;
    logic                      usable_hit;
    logic signed [SCORE_W-1:0] score_out;
    logic [MOVE_W-1:0]         stored_move;
  } result_t;

  typedef struct packed {
    logic   we;
    entry_t ent;
  } update_t;

endpackage

@@ sv/dmtt_eval.sv @@
// ============================================================================
// dmtt_eval: probe and store evaluation of one table entry
// Compares the stored entry with the request, builds the probe result and
// the replacement entry for a store.
// ============================================================================
module dmtt_eval
  import dmtt_pkg::*;
(
  input  logic [CMD_W-1:0] cmd_i,
  input  req_t             req_i,
  input  entry_t           ent_i,
  input  logic [AGE_W-1:0] gen_i,
  output result_t          res_o,
  output update_t          upd_o
);

  logic                    key_hit;
  logic signed [DEPTH_W:0] ent_depth;
  logic signed [DEPTH_W:0] req_depth;
  logic signed [SCORE_W:0] ply_s;
  logic signed [SCORE_W:0] st_score;
  logic signed [SCORE_W:0] adj_score;
  logic signed [SCORE_W:0] alpha_s;
  logic signed [SCORE_W:0] beta_s;
  logic signed [SCORE_W:0] in_score;
  logic signed [SCORE_W:0] tab_score;
  logic signed [SCORE_W:0] sat_score;
  logic                    deep;
  logic                    cut;
  logic                    keep;

  assign key_hit   = (ent_i.key == req_i.position_key);
  assign ent_depth = {2'b00, ent_i.depth};
  assign req_depth = {req_i.depth[DEPTH_W-1], req_i.depth};
  assign ply_s     = {{(SCORE_W + 1 - PLY_W){1'b0}}, req_i.ply};
  assign st_score  = {ent_i.score[SCORE_W-1], ent_i.score};
  assign alpha_s   = {req_i.alpha_bound[SCORE_W-1], req_i.alpha_bound};
  assign beta_s    = {req_i.beta_bound[SCORE_W-1], req_i.beta_bound};
  assign in_score  = {req_i.score[SCORE_W-1], req_i.score};
  assign deep      = (ent_depth >= req_depth);
  assign keep      = key_hit && (ent_depth > req_depth) && (ent_i.age == gen_i);

  always_comb begin
    if (st_score >= MATE_EDGE) begin
      adj_score = st_score - ply_s;
    end else if (st_score <= -MATE_EDGE) begin
      adj_score = st_score + ply_s;
    end else begin
      adj_score = st_score;
    end
  end

  always_comb begin
    case (ent_i.kind)
      KIND_EXACT: cut = 1'b1;
      KIND_UPPER: cut = (adj_score <= alpha_s);
      KIND_LOWER: cut = (adj_score >= beta_s);
      default:    cut = 1'b0;
    endcase
  end

  always_comb begin
    if (in_score >= MATE_EDGE) begin
      tab_score = in_score + ply_s;
    end else if (in_score <= -MATE_EDGE) begin
      tab_score = in_score - ply_s;
    end else begin
      tab_score = in_score;
    end
    if (tab_score > SCORE_LIMIT) begin
      sat_score = SCORE_LIMIT;
    end else if (tab_score < -SCORE_LIMIT) begin
      sat_score = -SCORE_LIMIT;
    end else begin
      sat_score = tab_score;
    end
  end

  always_comb begin
    res_o = '0;
    if ((cmd_i == CMD_PROBE) && key_hit) begin
      res_o.key_matched = 1'b1;
      res_o.stored_move = ent_i.move;
      if (deep && cut) begin
        res_o.usable_hit = 1'b1;
        res_o.score_out  = adj_score[SCORE_W-1:0];
      end
    end
  end

  always_comb begin
    upd_o.we        = (cmd_i == CMD_STORE) && !keep;
    upd_o.ent.key   = req_i.position_key;
    upd_o.ent.score = sat_score[SCORE_W-1:0];
    upd_o.ent.depth = req_i.depth[DEPTH_W-1] ? '0 : req_i.depth[SDEPTH_W-1:0];
    upd_o.ent.age   = gen_i;
    upd_o.ent.kind  = req_i.bound_kind;
    upd_o.ent.move  = req_i.move;
  end

endmodule

@@ sv/direct_mapped_transposition_table.sv @@
// ============================================================================
// direct_mapped_transposition_table: search-result table, one slot per index
// Probe, store, generation advance and table clear over a single-port
// entry memory with a registered read.
// ============================================================================
//
//  Channel   Direction  tdata (low bit up)                          tuser
//  s_axis    in         key, depth, alpha, beta, ply, score,        command
//                       bound_kind, move
//  m_axis    out        score_out, stored_move                      key_matched,
//                                                                   usable_hit
//
//  Probe and store go through index, memory read, and evaluate and write back;
//  when ENTRIES is not a power of two, a bit-serial key remainder runs first.
//  Advance goes straight to evaluation; clear writes one entry per cycle.
//  After reset a clearing pass over every entry runs with s_axis_tready low.
//  A result waits in the output register while the next transaction is taken;
//  evaluation holds until that register is free.
//
module direct_mapped_transposition_table
  import dmtt_pkg::*;
#(
  parameter int unsigned ENTRIES = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // position_key, depth, alpha_bound, beta_bound, ply, score, bound_kind, move
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // command
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // score_out, stored_move
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // key_matched, usable_hit
  output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

  localparam int unsigned IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam bit          IS_POW2  = ((ENTRIES & (ENTRIES - 1)) == 0);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES - 1);
  localparam logic [IDX_W:0]   ENTRIES_W = (IDX_W + 1)'(ENTRIES);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [5:0]       bit_q, bit_d;
  logic             clr_resp_q, clr_resp_d;
  logic [AGE_W-1:0] gen_q, gen_d;
  logic             out_valid_q, out_valid_d;
  result_t          out_res_q, out_res_d;
  logic [CMD_W-1:0] cmd_q, cmd_d;
  req_t             req_q, req_d;
  req_t             req_in;

  entry_t           mem [ENTRIES];
  entry_t           rd_ent_q;
  logic             rd_en;
  logic             mem_we;
  entry_t           mem_wdata;

  logic [IDX_W:0]   mod_sum;
  logic [IDX_W:0]   mod_red;

  result_t          eval_res;
  update_t          eval_upd;

  assign req_in.position_key = s_axis_tdata[63:0];
  assign req_in.depth        = s_axis_tdata[71:64];
  assign req_in.alpha_bound  = s_axis_tdata[89:72];
  assign req_in.beta_bound   = s_axis_tdata[107:90];
  assign req_in.ply          = s_axis_tdata[114:108];
  assign req_in.score        = s_axis_tdata[132:115];
  assign req_in.bound_kind   = s_axis_tdata[134:133];
  assign req_in.move         = s_axis_tdata[150:135];

  assign mod_sum = {idx_q, req_q.position_key[bit_q]};
  assign mod_red = (mod_sum >= ENTRIES_W) ? (mod_sum - ENTRIES_W) : mod_sum;

  dmtt_eval u_eval (
    .cmd_i (cmd_q),
    .req_i (req_q),
    .ent_i (rd_ent_q),
    .gen_i (gen_q),
    .res_o (eval_res),
    .upd_o (eval_upd)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_res_q.stored_move, out_res_q.score_out};
  assign m_axis_tuser  = {out_res_q.usable_hit, out_res_q.key_matched};

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    bit_d       = bit_q;
    clr_resp_d  = clr_resp_q;
    gen_d       = gen_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_res_d   = out_res_q;
    cmd_d       = cmd_q;
    req_d       = req_q;
    rd_en       = 1'b0;
    mem_we      = 1'b0;
    mem_wdata   = '0;
    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (idx_q == LAST_IDX) begin
          idx_d      = '0;
          clr_resp_d = 1'b0;
          state_d    = clr_resp_q ? S_EVAL : S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d = s_axis_tuser;
          req_d = req_in;
          case (s_axis_tuser)
            CMD_CLEAR: begin
              idx_d      = '0;
              clr_resp_d = 1'b1;
              state_d    = S_CLEAR;
            end
            CMD_ADVANCE: begin
              state_d = S_EVAL;
            end
            default: begin
              if (IS_POW2) begin
                idx_d   = req_in.position_key[IDX_W-1:0];
                state_d = S_READ;
              end else begin
                idx_d   = '0;
                bit_d   = 6'd63;
                state_d = S_MOD;
              end
            end
          endcase
        end
      end
      S_MOD: begin
        idx_d = mod_red[IDX_W-1:0];
        if (bit_q == 6'd0) begin
          state_d = S_READ;
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end
      S_READ: begin
        rd_en   = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_res_d   = eval_res;
          mem_we      = eval_upd.we;
          mem_wdata   = eval_upd.ent;
          if (cmd_q == CMD_ADVANCE) begin
            gen_d = gen_q + 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      idx_q       <= '0;
      bit_q       <= '0;
      clr_resp_q  <= 1'b0;
      gen_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      bit_q       <= bit_d;
      clr_resp_q  <= clr_resp_d;
      gen_q       <= gen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    req_q     <= req_d;
    out_res_q <= out_res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[idx_q] <= mem_wdata;
    end
    if (rd_en) begin
      rd_ent_q <= mem[idx_q];
    end
  end

endmodule

@@ sv/dmtt_checker.sv @@
// ============================================================================
// dmtt_checker: port-level checks of the transposition table
// Output stability, result flag and data consistency, saturated score range.
// ============================================================================
module dmtt_checker
  import dmtt_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic [IN_TUSER_W-1:0]  s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_hit_needs_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[1] && !m_axis_tuser[0]))
    else $error("usable hit without key match");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata == '0))
    else $error("miss result carries data");

  a_score_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> (m_axis_tdata[SCORE_W-1:0] == '0))
    else $error("score present without usable hit");

  a_score_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[SCORE_W-1:0] != 18'h20000))
    else $error("score out of saturated range");

endmodule

bind direct_mapped_transposition_table dmtt_checker u_dmtt_checker (.*);

@@ tb/sv/dmtt_result_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// dmtt_result_checker: predicts and checks transposition table results
// Watches both stream channels, keeps its own copy of the table and of the
// generation counter, queues one predicted result per accepted command and
// compares every returned result field by field against the oldest one.
// ============================================================================
module dmtt_result_checker
  import dmtt_pkg::*;
#(
  parameter int unsigned ENTRIES = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  // position_key, depth, alpha_bound, beta_bound, ply, score, bound_kind, move
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // command
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // score_out, stored_move
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // key_matched, usable_hit
  input  logic [OUT_TUSER_W-1:0] m_axis_tuser,
  output int unsigned            errors_o,
  output int unsigned            pending_o
);

  localparam int unsigned PAD_W = IN_TDATA_W - $bits(req_t);

  logic [KEY_W-1:0]          slot_key   [ENTRIES];
  logic signed [SCORE_W-1:0] slot_score [ENTRIES];
  logic [SDEPTH_W-1:0]       slot_depth [ENTRIES];
  logic [AGE_W-1:0]          slot_age   [ENTRIES];
  logic [KIND_W-1:0]         slot_kind  [ENTRIES];
  logic [MOVE_W-1:0]         slot_move  [ENTRIES];
  logic [AGE_W-1:0]          generation;

  result_t     expected_results [$];
  int unsigned fail_count = 0;
  int unsigned queued = 0;

  assign errors_o  = fail_count;
  assign pending_o = queued;

  function automatic void wipe_table();
    for (int i = 0; i < ENTRIES; i++) begin
      slot_key[i]   = '0;
      slot_score[i] = '0;
      slot_depth[i] = '0;
      slot_age[i]   = '0;
      slot_kind[i]  = '0;
      slot_move[i]  = '0;
    end
  endfunction

  function automatic result_t table_access(input logic [CMD_W-1:0] cmd, input req_t r);
    int      slot;
    int      s;
    int      d;
    int      ply;
    logic    keep;
    result_t res;
    res  = '0;
    slot = int'(r.position_key % 64'(ENTRIES));
    ply  = int'(r.ply);
    case (cmd)
      CMD_PROBE: begin
        if (slot_key[slot] == r.position_key) begin
          res.key_matched = 1'b1;
          res.stored_move = slot_move[slot];
          if (int'(slot_depth[slot]) >= int'(r.depth)) begin
            s = int'(slot_score[slot]);
            if (s >= int'(MATE_EDGE)) s -= ply;
            else if (s <= -int'(MATE_EDGE)) s += ply;
            if (slot_kind[slot] == KIND_EXACT ||
                (slot_kind[slot] == KIND_UPPER && s <= int'(r.alpha_bound)) ||
                (slot_kind[slot] == KIND_LOWER && s >= int'(r.beta_bound))) begin
              res.usable_hit = 1'b1;
              res.score_out  = SCORE_W'(s);
            end
          end
        end
      end
      CMD_STORE: begin
        keep = slot_key[slot] == r.position_key &&
               int'(slot_depth[slot]) > int'(r.depth) &&
               slot_age[slot] == generation;
        if (!keep) begin
          s = int'(r.score);
          d = int'(r.depth);
          if (s >= int'(MATE_EDGE)) s += ply;
          else if (s <= -int'(MATE_EDGE)) s -= ply;
          if (s > int'(SCORE_LIMIT)) s = int'(SCORE_LIMIT);
          if (s < -int'(SCORE_LIMIT)) s = -int'(SCORE_LIMIT);
          if (d < 0) d = 0;
          if (d > 127) d = 127;
          slot_key[slot]   = r.position_key;
          slot_score[slot] = SCORE_W'(s);
          slot_depth[slot] = SDEPTH_W'(d);
          slot_kind[slot]  = r.bound_kind;
          slot_age[slot]   = generation;
          slot_move[slot]  = r.move;
        end
      end
      CMD_ADVANCE: generation = generation + 1'b1;
      default: wipe_table();
    endcase
    return res;
  endfunction

  task automatic compare_field(input string what, input logic signed [31:0] want,
                               input logic signed [31:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, seen);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    req_t             r;
    result_t          got;
    result_t          want;
    logic [PAD_W-1:0] pad;
    if (!rst_ni) begin
      wipe_table();
      generation = '0;
      expected_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.score_out   = m_axis_tdata[SCORE_W-1:0];
        got.stored_move = m_axis_tdata[SCORE_W +: MOVE_W];
        got.key_matched = m_axis_tuser[0];
        got.usable_hit  = m_axis_tuser[1];
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, matched %0b usable %0b score %0d move %0h",
                   $time, got.key_matched, got.usable_hit, got.score_out, got.stored_move);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("key_matched", want.key_matched, got.key_matched);
          compare_field("usable_hit", want.usable_hit, got.usable_hit);
          compare_field("score_out", want.score_out, got.score_out);
          compare_field("stored_move", want.stored_move, got.stored_move);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        {pad, r.move, r.bound_kind, r.score, r.ply, r.beta_bound, r.alpha_bound, r.depth,
         r.position_key} = s_axis_tdata;
        expected_results.push_back(table_access(s_axis_tuser, r));
      end
    end
    queued = expected_results.size();
  end

endmodule

@@ tb/sv/direct_mapped_transposition_table_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// direct_mapped_transposition_table_tb: stimulus and verdict for the table
// Drives directed probe/store/advance/clear cases, then random store-probe
// sequences over a small key pool with colliding slots, with random stalls
// on both channels, one long output hold-off and two full drains.
// ============================================================================
module direct_mapped_transposition_table_tb;
  import dmtt_pkg::*;

  localparam int unsigned ENTRIES      = 4096;
  localparam int unsigned IDX_W        = $clog2(ENTRIES);
  localparam int unsigned TOTAL_ITEMS  = 1100;
  localparam int unsigned QUIET_TAIL   = 150;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned POOL_SIZE    = 24;
  localparam int unsigned PAD_W        = IN_TDATA_W - $bits(req_t);

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic [KEY_W-1:0] KEY_A    = 64'h0123_4567_89AB_C001;
  localparam logic [KEY_W-1:0] KEY_A2   = 64'hA5A5_0000_0000_0001;
  localparam logic [KEY_W-1:0] KEY_B    = 64'hFEDC_BA98_7654_3FFF;
  localparam logic [KEY_W-1:0] KEY_C    = 64'h8000_0000_0000_0800;
  localparam logic [KEY_W-1:0] KEY_D    = 64'h5555_AAAA_5555_A555;
  localparam logic [KEY_W-1:0] KEY_ONES = '1;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [IN_TUSER_W-1:0]  s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;

  int unsigned      errors;
  int unsigned      pending;
  int unsigned      items_sent = 0;
  int unsigned      cycles = 0;
  logic             idle_on = 1'b1;
  logic             hold_long = 1'b0;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  always #2 clk_i = ~clk_i;

  direct_mapped_transposition_table #(
    .ENTRIES(ENTRIES)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  dmtt_result_checker #(
    .ENTRIES(ENTRIES)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : result_sink
    int n;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        m_axis_tready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(negedge clk_i);
        hold_long = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return {$urandom, $urandom};
      default: return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endcase
  endfunction

  function automatic logic signed [SCORE_W-1:0] pick_score();
    int v;
    case ($urandom_range(0, 3))
      0:       v = int'($urandom_range(0, 200002)) - 100001;
      1:       v = int'($urandom_range(89800, 100001));
      2:       v = -int'($urandom_range(89800, 100001));
      default: v = int'($urandom_range(0, 400)) - 200;
    endcase
    return SCORE_W'(v);
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r.position_key = pick_key();
    r.depth        = DEPTH_W'($urandom);
    r.alpha_bound  = pick_score();
    r.beta_bound   = pick_score();
    r.ply          = PLY_W'($urandom_range(0, 127));
    r.score        = pick_score();
    r.bound_kind   = KIND_W'($urandom_range(0, 3));
    r.move         = MOVE_W'($urandom);
    return r;
  endfunction

  function automatic req_t mk(input logic [KEY_W-1:0] key, input int depth, input int alpha,
                              input int beta, input int ply, input int score,
                              input logic [KIND_W-1:0] kind, input logic [MOVE_W-1:0] move);
    req_t r;
    r.position_key = key;
    r.depth        = DEPTH_W'(depth);
    r.alpha_bound  = SCORE_W'(alpha);
    r.beta_bound   = SCORE_W'(beta);
    r.ply          = PLY_W'(ply);
    r.score        = SCORE_W'(score);
    r.bound_kind   = kind;
    r.move         = move;
    return r;
  endfunction

  task automatic send(input logic [CMD_W-1:0] cmd, input req_t r);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8) - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {PAD_W'(0), r.move, r.bound_kind, r.score, r.ply, r.beta_bound,
                      r.alpha_bound, r.depth, r.position_key};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin : stimulus
    req_t r;
    req_t q;
    int   sel;
    int   window;
    logic wrapped;
    logic held;
    logic saved_idle;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    rst_ni        = 1'b0;
    wrapped       = 1'b0;
    held          = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = {$urandom, $urandom};
      if (i >= 16) key_pool[i][IDX_W-1:0] = key_pool[i-16][IDX_W-1:0];
    end
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty slots match key zero
    send(CMD_PROBE, mk('0, 0, 0, 0, 0, 0, KIND_EXACT, '0));
    send(CMD_PROBE, mk('0, 127, 0, 0, 0, 0, KIND_EXACT, '0));
    send(CMD_PROBE, mk(KEY_ONES, -128, -100001, 100001, 127, 0, KIND_EXACT, '0));
    // mate scores shifted by ply in both directions
    send(CMD_STORE, mk(KEY_A, 127, 0, 0, 127, 100001, KIND_EXACT, 16'hFFFF));
    send(CMD_PROBE, mk(KEY_A, -128, 0, 0, 0, 0, KIND_EXACT, '0));
    send(CMD_PROBE, mk(KEY_A, 127, 0, 0, 127, 0, KIND_EXACT, '0));
    send(CMD_STORE, mk(KEY_B, -128, 0, 0, 127, -100001, KIND_UPPER, '0));
    send(CMD_PROBE, mk(KEY_B, 0, -100001, 100001, 127, 0, KIND_EXACT, '0));
    send(CMD_PROBE, mk(KEY_B, 0, -100001, 100001, 126, 0, KIND_EXACT, '0));
    send(CMD_PROBE, mk(KEY_B, 1, -100001, 100001, 0, 0, KIND_EXACT, '0));
    // lower bound against beta
    send(CMD_STORE, mk(KEY_C, 5, 0, 0, 5, 89999, KIND_LOWER, 16'h0F0F));
    send(CMD_PROBE, mk(KEY_C, 5, 0, 89999, 5, 0, KIND_EXACT, '0));
    send(CMD_PROBE, mk(KEY_C, 5, 0, 90000, 5, 0, KIND_EXACT, '0));
    send(CMD_PROBE, mk(KEY_C, 6, 0, 0, 5, 0, KIND_EXACT, '0));
    send(CMD_STORE, mk(KEY_D, 10, 0, 0, 0, 0, KIND_UNUSED, 16'h8001));
    send(CMD_PROBE, mk(KEY_D, 0, 100001, -100001, 0, 0, KIND_EXACT, '0));
    // keep deeper entry of the current generation, replace after advance
    send(CMD_STORE, mk(KEY_A, 10, 0, 0, 0, 5, KIND_EXACT, 16'h1234));
    send(CMD_PROBE, mk(KEY_A, 0, 0, 0, 0, 0, KIND_EXACT, '0));
    send(CMD_ADVANCE, mk('0, 0, 0, 0, 0, 0, KIND_EXACT, '0));
    send(CMD_STORE, mk(KEY_A, 10, 0, 0, 0, 5, KIND_EXACT, 16'h1234));
    send(CMD_PROBE, mk(KEY_A, 10, 0, 0, 0, 0, KIND_EXACT, '0));
    send(CMD_STORE, mk(KEY_A2, 0, 0, 0, 100, -90000, KIND_EXACT, 16'h00FF));
    send(CMD_PROBE, mk(KEY_A, 0, 0, 0, 0, 0, KIND_EXACT, '0));
    send(CMD_PROBE, mk(KEY_A2, 0, 0, 0, 0, 0, KIND_EXACT, '0));
    send(CMD_CLEAR, mk('0, 0, 0, 0, 0, 0, KIND_EXACT, '0));
    send(CMD_PROBE, mk(KEY_A2, 0, 0, 0, 0, 0, KIND_EXACT, '0));
    send(CMD_PROBE, mk('0, 0, 0, 0, 0, 0, KIND_EXACT, '0));

    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= TOTAL_ITEMS - QUIET_TAIL) idle_on = 1'b0;
      else if (items_sent % 97 == 0) idle_on = $urandom_range(0, 3) != 0;
      if (!wrapped && items_sent >= 400) begin
        drain();
        repeat (130) send(CMD_ADVANCE, rand_req());
        wrapped = 1'b1;
      end else if (!held && items_sent >= 700) begin
        saved_idle = idle_on;
        idle_on    = 1'b0;
        hold_long  = 1'b1;
        repeat (24) send($urandom_range(0, 1) ? CMD_STORE : CMD_PROBE, rand_req());
        idle_on = saved_idle;
        held    = 1'b1;
      end else begin
        sel = $urandom_range(0, 199);
        if (sel < 110) begin
          r = rand_req();
          send(CMD_STORE, r);
          if ($urandom_range(0, 3) == 0) begin
            q = rand_req();
            q.position_key = r.position_key;
            send(CMD_STORE, q);
          end
          q = rand_req();
          q.position_key = r.position_key;
          q.depth        = r.depth + DEPTH_W'($urandom_range(0, 4)) - DEPTH_W'(2);
          if ($urandom_range(0, 1)) q.ply = r.ply;
          if ($urandom_range(0, 2) != 0) begin
            window = int'(r.score) + int'($urandom_range(0, 6)) - 3;
            if (window > 100001) window = 100001;
            if (window < -100001) window = -100001;
            q.alpha_bound = SCORE_W'(window);
            q.beta_bound  = SCORE_W'(window);
          end
          send(CMD_PROBE, q);
        end else if (sel < 160) begin
          send(CMD_PROBE, rand_req());
        end else if (sel < 192) begin
          send(CMD_W'($urandom_range(0, 2)), rand_req());
        end else if (sel < 198) begin
          send(CMD_ADVANCE, rand_req());
        end else begin
          send(CMD_CLEAR, rand_req());
        end
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/dmtt_pkg.sv
sv/dmtt_eval.sv
sv/direct_mapped_transposition_table.sv
sv/dmtt_checker.sv
tb/sv/dmtt_result_checker.sv
tb/sv/direct_mapped_transposition_table_tb.sv
